>>> sv/mcfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the motor command frame packer.
// No dependencies; every other file imports this package.
package mcfp_pkg;

   // command kinds carried in tuser
   typedef enum logic [1:0] {
      CMD_CONTROL = 2'd0,
      CMD_DISABLE = 2'd1,
      CMD_ENABLE  = 2'd2,
      CMD_ZERO    = 2'd3
   } cmd_type;

   // frame bytes for special commands
   localparam logic [7:0] FILL_BYTE    = 8'hFF;
   localparam logic [7:0] TAIL_DISABLE = 8'hFD;
   localparam logic [7:0] TAIL_ENABLE  = 8'hFC;
   localparam logic [7:0] TAIL_ZERO    = 8'hFE;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_POS    = 3'd0;
   localparam logic [2:0] REG_VEL    = 3'd1;
   localparam logic [2:0] REG_STIFF  = 3'd2;
   localparam logic [2:0] REG_DAMP   = 3'd3;
   localparam logic [2:0] REG_TORQUE = 3'd4;

   // register reset values, Q15.16
   localparam logic [24:0] POS_MAX_RST    = 25'd819200;
   localparam logic [25:0] VEL_MAX_RST    = 26'd1966080;
   localparam logic [26:0] STIFF_MAX_RST  = 27'd32768000;
   localparam logic [24:0] DAMP_MAX_RST   = 25'd327680;
   localparam logic [25:0] TORQUE_MAX_RST = 26'd655360;

   // datapath widths
   localparam int LW   = 27;          // widest limit register
   localparam int OW   = LW + 1;      // offset and span
   localparam int DW   = OW + 1;      // divisor, 2 * span
   localparam int QW   = 16;          // quotient bits, one per divider stage
   localparam int NW   = OW + QW + 1; // numerator 2*off*levels + span
   localparam int NSTG = QW + 2;      // lane stages: clamp, numerator, divider

   typedef struct packed {
      logic [24:0] pos;
      logic [25:0] vel;
      logic [26:0] stiff;
      logic [24:0] damp;
      logic [25:0] torque;
   } lim_type;

   // pipeline control from the flow unit
   typedef struct packed {
      logic [NSTG:0] en;       // stage advance enables, top bit loads the output
      logic          v_first;  // first lane stage holds a word
      logic          v_last;   // last lane stage holds a word
      cmd_type       cmd_last; // command of the last lane stage
   } ctl_type;

endpackage

>>> sv/mcfp_csr.sv
`timescale 1ns / 1ps
// Limit registers behind the APB-style configuration port.
// Depends on mcfp_pkg for the register indexes and reset values.
module mcfp_csr import mcfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output lim_type     lim
);

   lim_type    lim_ff;
   logic       wr_en;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign lim        = lim_ff;

   // write limits, drop writes beyond the register list
   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff.pos    <= POS_MAX_RST;
         lim_ff.vel    <= VEL_MAX_RST;
         lim_ff.stiff  <= STIFF_MAX_RST;
         lim_ff.damp   <= DAMP_MAX_RST;
         lim_ff.torque <= TORQUE_MAX_RST;
      end else if (wr_en) begin
         unique case (idx)
            REG_POS:    lim_ff.pos    <= csr_pwdata[24:0];
            REG_VEL:    lim_ff.vel    <= csr_pwdata[25:0];
            REG_STIFF:  lim_ff.stiff  <= csr_pwdata[26:0];
            REG_DAMP:   lim_ff.damp   <= csr_pwdata[24:0];
            REG_TORQUE: lim_ff.torque <= csr_pwdata[25:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (idx)
         REG_POS:    csr_prdata = {7'd0, lim_ff.pos};
         REG_VEL:    csr_prdata = {6'd0, lim_ff.vel};
         REG_STIFF:  csr_prdata = {5'd0, lim_ff.stiff};
         REG_DAMP:   csr_prdata = {7'd0, lim_ff.damp};
         REG_TORQUE: csr_prdata = {6'd0, lim_ff.torque};
         default:    csr_prdata = 32'd0;
      endcase
   end

endmodule

>>> sv/mcfp_lane.sv
`timescale 1ns / 1ps
// One value lane: clamp, round-half-up numerator, and a 16-stage
// restoring divider giving one quotient bit per stage. Uses mcfp_pkg.
module mcfp_lane import mcfp_pkg::*; (
   input  logic                   clock,
   input  logic [NSTG-1:0]        en,
   input  logic signed [31:0]     x,
   input  logic [LW-1:0]          lim,
   input  logic                   sym,   // range is -lim..+lim, else 0..lim
   input  logic                   wide,  // 16-bit code, else 12-bit
   output logic [QW-1:0]          code
);

   // stage 0: clamp and offset
   logic signed [33:0] xs, lim_s, lo_s, xc_s, off_s;
   logic [OW-1:0]      off_in, off_ff, span_in, span_ff;

   always_comb begin
      xs    = 34'(x);
      lim_s = signed'({7'd0, lim});
      lo_s  = sym ? -lim_s : 34'sd0;
      if (xs < lo_s)
         xc_s = lo_s;
      else if (xs > lim_s)
         xc_s = lim_s;
      else
         xc_s = xs;
      off_s   = xc_s - lo_s;
      off_in  = off_s[OW-1:0];
      span_in = sym ? {lim, 1'b0} : {1'b0, lim};
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         off_ff  <= off_in;
         span_ff <= span_in;
      end
   end

   // stage 1: numerator 2*off*(2^bits-1) + span, divisor 2*span
   logic [NW-1:0] rem_ff [0:QW];
   logic [DW-1:0] den_ff [0:QW];
   logic [QW-1:0] quo_ff [0:QW];
   logic [NW-1:0] off_w, off_sh, num_in;

   always_comb begin
      off_w  = {{(NW-OW){1'b0}}, off_ff};
      off_sh = wide ? (off_w << QW) : (off_w << (QW - 4));
      num_in = ((off_sh - off_w) << 1) + {{(NW-OW){1'b0}}, span_ff};
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         rem_ff[0] <= num_in;
         den_ff[0] <= {span_ff, 1'b0};
         quo_ff[0] <= '0;
      end
   end

   // divider stages, most significant quotient bit first
   for (genvar s = 1; s <= QW; s++) begin : g_div
      localparam int BIT = QW - s;
      logic [NW-1:0] dsh, diff, rem_in;
      logic [QW-1:0] quo_in;
      logic          ge;

      always_comb begin
         dsh    = {{(NW-DW){1'b0}}, den_ff[s-1]} << BIT;
         diff   = rem_ff[s-1] - dsh;
         ge     = rem_ff[s-1] >= dsh;
         rem_in = ge ? diff : rem_ff[s-1];
         quo_in = quo_ff[s-1];
         quo_in[BIT] = ge;
      end

      always_ff @(posedge clock) begin
         if (en[1+s]) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_ff[s-1];
            quo_ff[s] <= quo_in;
         end
      end
   end

   // zero span gives code zero
   assign code = (den_ff[QW] == '0) ? '0 : quo_ff[QW];

endmodule

>>> sv/mcfp_flow.sv
`timescale 1ns / 1ps
// Valid bits, command pipeline and per-stage advance enables.
// Uses mcfp_pkg for the stage count and control struct.
module mcfp_flow import mcfp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  cmd_type cmd_in,
   output logic    req_tready,
   input  logic    rsp_tready,
   output logic    rsp_tvalid,
   output ctl_type ctl
);

   logic [NSTG-1:0] v_ff, v_in;
   logic [NSTG:0]   en;
   cmd_type         cmd_ff [0:NSTG-1];
   logic            out_v_ff, out_v_in;

   // a stage advances when empty or when the next one advances
   assign en[NSTG] = !out_v_ff || rsp_tready;
   for (genvar s = 0; s < NSTG; s++) begin : g_en
      assign en[s] = !v_ff[s] || en[s+1];
   end

   // advance valid bits
   always_comb begin
      v_in[0] = en[0] ? req_tvalid : v_ff[0];
      for (int s = 1; s < NSTG; s++) begin
         v_in[s] = en[s] ? v_ff[s-1] : v_ff[s];
      end
      out_v_in = en[NSTG] ? v_ff[NSTG-1] : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else begin
         v_ff     <= v_in;
         out_v_ff <= out_v_in;
      end
   end

   // carry the command beside the data
   always_ff @(posedge clock) begin
      if (en[0])
         cmd_ff[0] <= cmd_in;
   end
   for (genvar s = 1; s < NSTG; s++) begin : g_cmd
      always_ff @(posedge clock) begin
         if (en[s])
            cmd_ff[s] <= cmd_ff[s-1];
      end
   end

   assign req_tready   = en[0];
   assign rsp_tvalid   = out_v_ff;
   assign ctl.en       = en;
   assign ctl.v_first  = v_ff[0];
   assign ctl.v_last   = v_ff[NSTG-1];
   assign ctl.cmd_last = cmd_ff[NSTG-1];

endmodule

>>> sv/mit_command_frame_packer.sv
`timescale 1ns / 1ps
// Top level of the motor command frame packer: limit registers, five
// value lanes, pipeline control and the frame output register. Uses mcfp_pkg.
//
//   channel   dir  ports              payload
//   req_      in   tvalid/tready      tuser: command; tdata: five Q15.16 values
//   rsp_      out  tvalid/tready      tdata: frame byte0..byte7
//   csr_      in   APB write/read     five limit registers at 0x00..0x10
//
// One word per cycle enters and leaves while rsp_tready stays high; nineteen register
// stages (one clamp stage, one numerator stage, 16 divider stages of one quotient bit each
// and the output register) lie between the accepting edge and rsp_tvalid.
// Reset clears all valid bits and restores the limit registers.
// Each stage advances when it is empty or its successor advances, so a stall
// at rsp_ fills bubbles before req_tready drops.
module mit_command_frame_packer import mcfp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,  // target_pos, target_vel, stiffness, damping, ff_torque
   input  logic [1:0]   req_tuser,  // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // byte0, byte1, ... byte7
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   lim_type       lim;
   ctl_type       ctl;
   logic [QW-1:0] pos_code, vel_code, stiff_code, damp_code, torq_code;
   logic [63:0]   frame_in, frame_ff;

   mcfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .lim         (lim)
   );

   mcfp_flow u_flow (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .cmd_in     (cmd_type'(req_tuser)),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .ctl        (ctl)
   );

   mcfp_lane u_pos (
      .clock (clock), .en (ctl.en[NSTG-1:0]), .x (req_tdata[31:0]),
      .lim ({2'd0, lim.pos}), .sym (1'b1), .wide (1'b1), .code (pos_code)
   );
   mcfp_lane u_vel (
      .clock (clock), .en (ctl.en[NSTG-1:0]), .x (req_tdata[63:32]),
      .lim ({1'b0, lim.vel}), .sym (1'b1), .wide (1'b0), .code (vel_code)
   );
   mcfp_lane u_stiff (
      .clock (clock), .en (ctl.en[NSTG-1:0]), .x (req_tdata[95:64]),
      .lim (lim.stiff), .sym (1'b0), .wide (1'b0), .code (stiff_code)
   );
   mcfp_lane u_damp (
      .clock (clock), .en (ctl.en[NSTG-1:0]), .x (req_tdata[127:96]),
      .lim ({2'd0, lim.damp}), .sym (1'b0), .wide (1'b0), .code (damp_code)
   );
   mcfp_lane u_torq (
      .clock (clock), .en (ctl.en[NSTG-1:0]), .x (req_tdata[159:128]),
      .lim ({1'b0, lim.torque}), .sym (1'b1), .wide (1'b0), .code (torq_code)
   );

   // pack the frame, byte0 in the low bits
   always_comb begin
      case (ctl.cmd_last)
         CMD_CONTROL: frame_in = {torq_code[7:0],
                                  damp_code[3:0], torq_code[11:8],
                                  damp_code[11:4],
                                  stiff_code[7:0],
                                  vel_code[3:0], stiff_code[11:8],
                                  vel_code[11:4],
                                  pos_code[7:0],
                                  pos_code[15:8]};
         CMD_DISABLE: frame_in = {TAIL_DISABLE, {7{FILL_BYTE}}};
         CMD_ENABLE:  frame_in = {TAIL_ENABLE, {7{FILL_BYTE}}};
         default:     frame_in = {TAIL_ZERO, {7{FILL_BYTE}}};
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (ctl.en[NSTG])
         frame_ff <= frame_in;
   end

   assign rsp_tdata = frame_ff;

   // an accepted word lands in the first lane stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> ctl.v_first)
      else $error("accepted word missing from first stage");

   // twelve-bit lanes never set the upper quotient bits
   a_narrow_codes: assert property (@(posedge clock) disable iff (reset)
      ctl.v_last |-> vel_code[15:12] == 4'd0 && stiff_code[15:12] == 4'd0 &&
                     damp_code[15:12] == 4'd0 && torq_code[15:12] == 4'd0)
      else $error("twelve-bit code overflow");

   // a word waiting at the output blocks the last stage from moving in
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(frame_ff))
      else $error("pending frame overwritten");

   // nothing leaves right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

>>> bench/mit_command_frame_packer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for mit_command_frame_packer: directed table, then random
// commands over several limit settings, checked against a frame predictor.
// Depends on mcfp_pkg and the block's top level only.
module mit_command_frame_packer_tb;
   import mcfp_pkg::*;

   localparam int          RANDOM_PER_PHASE = 150;
   localparam int          PHASE_COUNT      = 7;
   localparam int          LONG_HOLD        = 80;
   localparam int          DRAIN_CYCLES     = 40;
   localparam int unsigned CYCLE_LIMIT      = 200000;
   localparam logic [31:0] VMIN             = 32'h8000_0000;
   localparam logic [31:0] VMAX             = 32'h7FFF_FFFF;

   // idle profiles of the two sides, in the order the run walks them
   typedef enum logic [1:0] {
      PACE_SLOW_SINK,   // sender idles 31 %, receiver 63 %
      PACE_SLOW_SOURCE, // sender idles 63 %, receiver 31 %
      PACE_FULL_RATE    // neither side idles
   } pace_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] pos;
      logic [31:0] vel;
      logic [31:0] kp;
      logic [31:0] kd;
      logic [31:0] tq;
   } command_type;

   // one directed row: command word, and the frame where it is obvious
   typedef struct packed {
      command_type word;
      logic        known;
      logic [63:0] frame;
   } dir_row_type;

   localparam logic [63:0] FRAME_ZEROS = 64'h0;
   localparam logic [63:0] FRAME_ONES  = {8{FILL_BYTE}};
   localparam logic [63:0] FRAME_MID   = 64'h0008_0000_0080_0080; // byte7 .. byte0

   localparam dir_row_type DIRECTED_ROWS [16] = '{
      '{'{CMD_CONTROL, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, FRAME_MID},
      '{'{CMD_CONTROL, VMIN, VMIN, VMIN, VMIN, VMIN}, 1'b1, FRAME_ZEROS},
      '{'{CMD_CONTROL, VMAX, VMAX, VMAX, VMAX, VMAX}, 1'b1, FRAME_ONES},
      '{'{CMD_CONTROL, 32'd819200, 32'd1966080, 32'd32768000, 32'd327680, 32'd655360},
        1'b1, FRAME_ONES},
      '{'{CMD_CONTROL, -32'sd819200, -32'sd1966080, 32'd0, 32'd0, -32'sd655360},
        1'b1, FRAME_ZEROS},
      '{'{CMD_DISABLE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
        {TAIL_DISABLE, {7{FILL_BYTE}}}},
      '{'{CMD_ENABLE, VMAX, VMAX, VMAX, VMAX, VMAX}, 1'b1, {TAIL_ENABLE, {7{FILL_BYTE}}}},
      '{'{CMD_ZERO, VMIN, VMIN, VMIN, VMIN, VMIN}, 1'b1, {TAIL_ZERO, {7{FILL_BYTE}}}},
      '{'{CMD_ZERO, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
          32'h5555_5555}, 1'b1, {TAIL_ZERO, {7{FILL_BYTE}}}},
      '{'{CMD_ENABLE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
          32'hAAAA_AAAA}, 1'b1, {TAIL_ENABLE, {7{FILL_BYTE}}}},
      '{'{CMD_CONTROL, 32'd819201, -32'sd1966081, 32'd32768001, -32'sd1, 32'd655361},
        1'b0, FRAME_ZEROS},
      '{'{CMD_CONTROL, 32'd1, -32'sd1, 32'd1, 32'd1, -32'sd1}, 1'b0, FRAME_ZEROS},
      '{'{CMD_CONTROL, -32'sd1, 32'd1, -32'sd5, VMIN, 32'd1}, 1'b0, FRAME_ZEROS},
      '{'{CMD_CONTROL, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
          32'h5555_5555}, 1'b0, FRAME_ZEROS},
      '{'{CMD_CONTROL, 32'd409600, -32'sd983040, 32'd16384000, 32'd163840, 32'd327680},
        1'b0, FRAME_ZEROS},
      '{'{CMD_CONTROL, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_8000,
          32'hFFFF_8000}, 1'b0, FRAME_ZEROS}
   };

   // upper ends of the stated register ranges, by register index
   localparam int unsigned LIMIT_HIGH [5] = '{16777216, 33554432, 67108864, 16777216,
                                             33554432};

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [159:0] req_tdata;  // target_pos, target_vel, stiffness, damping, ff_torque
   logic [1:0]   req_tuser;  // command
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;  // byte0, byte1, ... byte7
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [4:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   lim_type      limits;
   logic [63:0]  pending_frames [$];
   int           mismatch_count;
   int unsigned  cycle_count = 0;
   pace_type     pace;
   logic         long_hold_req;

   mit_command_frame_packer dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at cycle %0d", what, got, want,
               cycle_count);
      mismatch_count++;
   endtask

   // round-half-up code of x clamped to [lo, hi] over 2^bits - 1 levels
   function automatic longint scaled_code(input longint x, input longint lo,
                                          input longint hi, input int bits);
      longint levels;
      longint span;
      longint clamped;
      levels  = (longint'(1) << bits) - 1;
      span    = hi - lo;
      clamped = (x < lo) ? lo : (x > hi) ? hi : x;
      if (span == 0) return 0;
      return ((clamped - lo) * levels * 2 + span) / (2 * span);
   endfunction

   function automatic logic [63:0] command_frame(input command_type word);
      logic [15:0] p;
      logic [11:0] v;
      logic [11:0] kp;
      logic [11:0] kd;
      logic [11:0] t;
      case (word.cmd)
         CMD_DISABLE: return {TAIL_DISABLE, {7{FILL_BYTE}}};
         CMD_ENABLE:  return {TAIL_ENABLE, {7{FILL_BYTE}}};
         CMD_ZERO:    return {TAIL_ZERO, {7{FILL_BYTE}}};
         default: begin
            p  = 16'(scaled_code(longint'($signed(word.pos)), -longint'(limits.pos),
                                 longint'(limits.pos), 16));
            v  = 12'(scaled_code(longint'($signed(word.vel)), -longint'(limits.vel),
                                 longint'(limits.vel), 12));
            kp = 12'(scaled_code(longint'($signed(word.kp)), 0,
                                 longint'(limits.stiff), 12));
            kd = 12'(scaled_code(longint'($signed(word.kd)), 0,
                                 longint'(limits.damp), 12));
            t  = 12'(scaled_code(longint'($signed(word.tq)), -longint'(limits.torque),
                                 longint'(limits.torque), 12));
            // byte7 down to byte0
            return {t[7:0], kd[3:0], t[11:8], kd[11:4], kp[7:0], v[3:0], kp[11:8],
                    v[11:4], p[7:0], p[15:8]};
         end
      endcase
   endfunction

   // value around [lo, hi]: mostly near the range, some edges, some any pattern
   function automatic logic [31:0] pick_value(input longint lo, input longint hi);
      longint            span;
      longint unsigned   width;
      longint unsigned   draw;
      span = hi - lo;
      case ($urandom_range(9))
         0: return $urandom;
         1: begin
            case ($urandom_range(5))
               0: return 32'(lo);
               1: return 32'(hi);
               2: return 32'(lo - 1);
               3: return 32'(hi + 1);
               4: return 0;
               default: return -1;
            endcase
         end
         default: begin
            width = span + span / 4 + 1;
            draw  = {$urandom, $urandom};
            return 32'(lo - span / 8 + longint'(draw % width));
         end
      endcase
   endfunction

   function automatic command_type random_command();
      command_type word;
      word.cmd = ($urandom_range(99) < 85) ? CMD_CONTROL : cmd_type'($urandom_range(1, 3));
      word.pos = pick_value(-longint'(limits.pos), longint'(limits.pos));
      word.vel = pick_value(-longint'(limits.vel), longint'(limits.vel));
      word.kp  = pick_value(0, longint'(limits.stiff));
      word.kd  = pick_value(0, longint'(limits.damp));
      word.tq  = pick_value(-longint'(limits.torque), longint'(limits.torque));
      return word;
   endfunction

   // offer one word after a random gap, hold it until accepted
   task automatic send_word(input command_type word, input logic [63:0] frame);
      int gap_pct;
      gap_pct = (pace == PACE_SLOW_SINK) ? 31 : (pace == PACE_SLOW_SOURCE) ? 63 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser  = word.cmd;
      req_tdata  = {word.tq, word.kd, word.kp, word.vel, word.pos};
      req_tvalid = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_tready);
      pending_frames.push_back(frame);
      @(negedge clock);
   endtask

   // write one limit register, then read it back
   task automatic write_limit(input logic [2:0] index, input logic [31:0] value);
      logic [31:0] stored;
      case (index)
         REG_POS:    begin limits.pos    = value[24:0]; stored = {7'd0, value[24:0]}; end
         REG_VEL:    begin limits.vel    = value[25:0]; stored = {6'd0, value[25:0]}; end
         REG_STIFF:  begin limits.stiff  = value[26:0]; stored = {5'd0, value[26:0]}; end
         REG_DAMP:   begin limits.damp   = value[24:0]; stored = {7'd0, value[24:0]}; end
         default:    begin limits.torque = value[25:0]; stored = {6'd0, value[25:0]}; end
      endcase
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata !== stored)
         report_mismatch("limit readback", 64'(csr_prdata), 64'(stored));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_frames.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin : sink_pacing
      int  hold_left;
      bit  hold_served;
      hold_left   = 0;
      hold_served = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_served) begin
            hold_left   = LONG_HOLD;
            hold_served = 1;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = $urandom_range(99) >=
                         ((pace == PACE_SLOW_SINK) ? 63 : (pace == PACE_SLOW_SOURCE) ? 31 : 0);
         end
      end
   end

   // compare each accepted frame with the oldest pending one
   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_frames.size() == 0) begin
            report_mismatch("frame with nothing pending", rsp_tdata, 64'h0);
         end else begin
            want = pending_frames.pop_front();
            for (int k = 0; k < 8; k++) begin
               if (rsp_tdata[8*k +: 8] !== want[8*k +: 8])
                  report_mismatch($sformatf("byte%0d", k), 64'(rsp_tdata[8*k +: 8]),
                                  64'(want[8*k +: 8]));
            end
         end
      end
   end

   initial begin : stimulus
      logic [31:0] setting [5];
      command_type word;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = CMD_CONTROL;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatch_count = 0;
      pace           = PACE_SLOW_SINK;
      long_hold_req  = 1'b0;
      limits         = '{POS_MAX_RST, VEL_MAX_RST, STIFF_MAX_RST, DAMP_MAX_RST,
                         TORQUE_MAX_RST};
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // directed table under the reset limits
      foreach (DIRECTED_ROWS[i]) begin
         send_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].known ?
                   DIRECTED_ROWS[i].frame : command_frame(DIRECTED_ROWS[i].word));
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // retune the limits only once the pipeline is empty
         if (phase > 0) begin
            wait_drained();
            @(negedge clock);
            for (int r = REG_POS; r <= REG_TORQUE; r++) begin
               case (phase)
                  1: setting[r] = $urandom_range(1, LIMIT_HIGH[r]);
                  2: setting[r] = 32'd1;
                  3: setting[r] = LIMIT_HIGH[r];
                  4: setting[r] = 32'hFFFF_FFFF;
                  5: setting[r] = 32'd0;
                  default: setting[r] = (r == REG_VEL) ? 32'd0 :
                                        (r == REG_DAMP) ? 32'd1 :
                                        $urandom_range(1, LIMIT_HIGH[r]);
               endcase
               write_limit(r[2:0], setting[r]);
            end
         end
         pace = (phase < 3) ? PACE_SLOW_SINK : (phase < 5) ? PACE_SLOW_SOURCE :
                PACE_FULL_RATE;
         // stall the receiver while the sender keeps pushing
         if (phase == PHASE_COUNT - 1) long_hold_req = 1'b1;
         repeat (RANDOM_PER_PHASE) begin
            word = random_command();
            send_word(word, command_frame(word));
         end
         req_tvalid = 1'b0;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
sv/mcfp_pkg.sv
sv/mcfp_csr.sv
sv/mcfp_lane.sv
sv/mcfp_flow.sv
sv/mit_command_frame_packer.sv
bench/mit_command_frame_packer_tb.sv
